[rtl/ang_pkg.sv]
// Shared types, register codes and constants of the audio noise gate.
`timescale 1ns / 1ps
`default_nettype none

package ang_pkg;

    // Default sizes for the top-level parameters.
    localparam int DEF_DELAY_DEPTH   = 512;
    localparam int DEF_CHANNEL_COUNT = 2;
    localparam int DEF_SAMPLE_BITS   = 24;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register field widths.
    localparam int THR_W  = 23;
    localparam int COEF_W = 16;
    localparam int HOLD_W = 16;
    localparam int LA_W   = 9;

    // Q0.16 full scale and the rounding half used by the gain blend.
    localparam logic [COEF_W-1:0] UNITY  = 16'hFFFF;
    localparam logic [31:0]       Q_HALF = 32'd32767;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_ATTACK    = 3'd1,
        CFG_RELEASE   = 3'd2,
        CFG_HOLD      = 3'd3,
        CFG_FLOOR     = 3'd4,
        CFG_LOOKAHEAD = 3'd5,
        CFG_BYPASS    = 3'd6
    } t_cfg_idx;

    // All configuration registers as one group.
    typedef struct packed {
        logic [THR_W-1:0]  threshold;
        logic [COEF_W-1:0] attack;
        logic [COEF_W-1:0] release_c;
        logic [HOLD_W-1:0] hold_length;
        logic [COEF_W-1:0] floor_gain;
        logic [LA_W-1:0]   lookahead;
        logic              bypass;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        threshold:   23'd838861,
        attack:      16'd1351,
        release_c:   16'd14,
        hold_length: 16'd480,
        floor_gain:  16'd655,
        lookahead:   9'd96,
        bypass:      1'b0
    };

endpackage

`default_nettype wire

[rtl/ang_ifs.sv]
// Valid/ready channel interfaces for samples in, results out and configuration writes.
`timescale 1ns / 1ps
`default_nettype none

// Input sample channel: one item is one tagged sample.
interface ang_in_if #(
    parameter int SAMPLE_BITS = ang_pkg::DEF_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic                          channel_index;
    logic signed [SAMPLE_BITS-1:0] input_sample;

    modport source (output valid, output channel_index, output input_sample, input ready);
    modport sink   (input valid, input channel_index, input input_sample, output ready);
endinterface

// Result channel: one item is one gated sample.
interface ang_out_if #(
    parameter int SAMPLE_BITS = ang_pkg::DEF_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic                          out_channel;
    logic signed [SAMPLE_BITS-1:0] gated_sample;
    logic                          gate_open;

    modport source (output valid, output out_channel, output gated_sample,
                    output gate_open, input ready);
    modport sink   (input valid, input out_channel, input gated_sample,
                    input gate_open, output ready);
endinterface

// Configuration write channel.
interface ang_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ang_pkg::CFG_IDX_W-1:0]   index;
    logic [ang_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/ang_cfg_regs.sv]
// Configuration register file of the audio noise gate.
`timescale 1ns / 1ps
`default_nettype none

module ang_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ang_cfg_if.sink       i_cfg,
    output ang_pkg::t_cfg o_cfg
);
    import ang_pkg::*;

    t_cfg r_cfg;

    // Writes are always taken; unknown indexes are dropped.
    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_THRESHOLD: r_cfg.threshold   <= i_cfg.data[THR_W-1:0];
                CFG_ATTACK:    r_cfg.attack      <= i_cfg.data[COEF_W-1:0];
                CFG_RELEASE:   r_cfg.release_c   <= i_cfg.data[COEF_W-1:0];
                CFG_HOLD:      r_cfg.hold_length <= i_cfg.data[HOLD_W-1:0];
                CFG_FLOOR:     r_cfg.floor_gain  <= i_cfg.data[COEF_W-1:0];
                CFG_LOOKAHEAD: r_cfg.lookahead   <= i_cfg.data[LA_W-1:0];
                CFG_BYPASS:    r_cfg.bypass      <= i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/audio_noise_gate.sv]
// Top level of the audio noise gate: per-channel state memory, delay memory and sequencer.
`timescale 1ns / 1ps
`default_nettype none

// Multichannel noise gate with hold and lookahead. Each input item is one signed sample
// tagged with its channel and yields exactly one result item, in order. Envelope, hold
// count, gate level, ring write position and ring fill count of each channel sit in a small
// state memory that is read when an item is accepted and written back once per item; the
// lookahead samples sit in a delay memory of CHANNEL_COUNT x DELAY_DEPTH entries, written
// and read in the same cycle. Items are processed one at a time, through the chain of
// envelope multiply, gate multiply, gain blend and output multiply behind the single
// read-modify-write of the channel state; in bypass only the load and output steps run
// and the state is not written back. A finished result waits in the output register
// while the block accepts the next item. The delay memory needs no clearing after reset:
// a fill count per channel makes taps that were never written read as zero. Configuration
// is meant to be written only while no item is in flight.
module audio_noise_gate #(
    parameter int DELAY_DEPTH   = ang_pkg::DEF_DELAY_DEPTH,
    parameter int CHANNEL_COUNT = ang_pkg::DEF_CHANNEL_COUNT,
    parameter int SAMPLE_BITS   = ang_pkg::DEF_SAMPLE_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ang_cfg_if.sink   i_cfg,
    ang_in_if.sink    i_smp,
    ang_out_if.source o_res
);
    import ang_pkg::*;

    localparam int PW   = $clog2(DELAY_DEPTH);
    localparam int CW   = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int EW   = SAMPLE_BITS - 1;
    localparam int CMPW = (EW > THR_W) ? EW : THR_W;
    localparam logic [PW-1:0] POS_LAST = PW'(DELAY_DEPTH - 1);
    localparam logic [EW-1:0] MAG_MAX  = '1;

    // Per-channel state word.
    typedef struct packed {
        logic [EW-1:0]     env;
        logic [HOLD_W-1:0] hold;
        logic [COEF_W-1:0] gate;
        logic [PW-1:0]     wpos;
        logic [PW-1:0]     fill;
    } t_chan;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_ENV, S_GATE, S_GUP, S_GMUL, S_GDIV, S_APPLY, S_OUT
    } t_state;

    t_cfg   r_cfg;
    t_state r_state;

    // Memories.
    t_chan                  st_mem  [CHANNEL_COUNT];
    logic [SAMPLE_BITS-1:0] dly_mem [CHANNEL_COUNT][DELAY_DEPTH];

    logic [CHANNEL_COUNT-1:0] r_st_vld;
    t_chan                    r_st_q;
    logic                     r_st_vq;
    logic [SAMPLE_BITS-1:0]   r_dly_q;

    // Item registers.
    logic [CW-1:0]                 r_ch;
    logic                          r_ch_field;
    logic signed [SAMPLE_BITS-1:0] r_x;
    t_chan                         r_cur;
    logic signed [SAMPLE_BITS+16:0] r_env_prod;
    logic                          r_dly_zero;
    logic                          r_dly_fill;
    logic [EW-1:0]                 r_env;
    logic signed [SAMPLE_BITS-1:0] r_delayed;
    logic [HOLD_W-1:0]             r_hold;
    logic signed [33:0]            r_gprod;
    logic [COEF_W-1:0]             r_gate;
    logic [31:0]                   r_gmul;
    logic [16:0]                   r_gain;
    logic [SAMPLE_BITS-1:0]        r_res;
    logic                          r_gopen;

    // Output registers.
    logic                   r_o_valid;
    logic                   r_o_chan;
    logic [SAMPLE_BITS-1:0] r_o_sample;
    logic                   r_o_open;

    ang_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (r_cfg)
    );

    // Handshakes and channel selection.
    logic          smp_acc;
    logic [CW-1:0] in_ch;

    assign i_smp.ready = (r_state == S_IDLE);
    assign smp_acc     = i_smp.valid && i_smp.ready;
    assign in_ch       = (CHANNEL_COUNT == 1) ? '0 : CW'(i_smp.channel_index);

    assign o_res.valid        = r_o_valid;
    assign o_res.out_channel  = r_o_chan;
    assign o_res.gated_sample = r_o_sample;
    assign o_res.gate_open    = r_o_open;

    // Load step: state word, magnitude, envelope product and delay taps.
    t_chan                          cur;
    logic [SAMPLE_BITS:0]           x_ext;
    logic [SAMPLE_BITS:0]           abs_x;
    logic [EW-1:0]                  mag;
    logic signed [SAMPLE_BITS-1:0]  env_diff;
    logic [COEF_W-1:0]              env_coef;
    logic signed [SAMPLE_BITS+16:0] env_prod;
    logic [PW-1:0]                  dly_amt;
    logic [PW:0]                    rd_wrap;
    logic [PW-1:0]                  rd_pos;

    always_comb begin
        cur      = r_st_vq ? r_st_q : '0;
        x_ext    = {r_x[SAMPLE_BITS-1], r_x};
        abs_x    = x_ext[SAMPLE_BITS] ? (~x_ext + 1'b1) : x_ext;
        mag      = (abs_x > {2'b00, MAG_MAX}) ? MAG_MAX : abs_x[EW-1:0];
        env_diff = $signed({1'b0, mag}) - $signed({1'b0, cur.env});
        env_coef = (mag > cur.env) ? r_cfg.attack : r_cfg.release_c;
        env_prod = $signed({1'b0, env_coef}) * env_diff;
        dly_amt  = (int'(r_cfg.lookahead) > DELAY_DEPTH - 1) ? POS_LAST
                                                              : PW'(r_cfg.lookahead);
        rd_wrap  = (cur.wpos >= dly_amt)
                 ? ((PW+1)'(cur.wpos) - (PW+1)'(dly_amt))
                 : ((PW+1)'(cur.wpos) + (PW+1)'(DELAY_DEPTH) - (PW+1)'(dly_amt));
        rd_pos   = rd_wrap[PW-1:0];
    end

    // Envelope update.
    logic signed [SAMPLE_BITS+16:0] env_sum;
    logic [EW-1:0]                  n_env;

    always_comb begin
        env_sum = $signed((SAMPLE_BITS+17)'(r_cur.env)) + (r_env_prod >>> 16);
        n_env   = env_sum[EW-1:0];
    end

    // Hold count, gate target and gate product.
    logic              above;
    logic              tgt_open;
    logic [COEF_W-1:0] tgt;
    logic [HOLD_W-1:0] n_hold;
    logic signed [16:0] gdiff;
    logic [COEF_W-1:0] gcoef;
    logic signed [33:0] gprod;

    always_comb begin
        above = CMPW'(r_env) > CMPW'(r_cfg.threshold);
        if (above) begin
            n_hold   = r_cfg.hold_length;
            tgt_open = 1'b1;
        end else if (r_cur.hold != '0) begin
            n_hold   = r_cur.hold - 1'b1;
            tgt_open = 1'b1;
        end else begin
            n_hold   = r_cur.hold;
            tgt_open = 1'b0;
        end
        tgt   = tgt_open ? UNITY : '0;
        gdiff = $signed({1'b0, tgt}) - $signed({1'b0, r_cur.gate});
        gcoef = (tgt > r_cur.gate) ? r_cfg.attack : r_cfg.release_c;
        gprod = $signed({1'b0, gcoef}) * gdiff;
    end

    // Gate update and the state word written back.
    logic signed [33:0] gsum;
    logic [COEF_W-1:0]  n_gate;
    t_chan              n_st;

    always_comb begin
        gsum        = $signed(34'(r_cur.gate)) + (r_gprod >>> 16);
        n_gate      = gsum[COEF_W-1:0];
        n_st.env    = r_env;
        n_st.hold   = r_hold;
        n_st.gate   = n_gate;
        n_st.wpos   = (r_cur.wpos == POS_LAST) ? '0 : r_cur.wpos + PW'(1);
        n_st.fill   = (r_cur.fill == POS_LAST) ? r_cur.fill : r_cur.fill + PW'(1);
    end

    // Gain blend: divide by 65535 with a shift-add correction, then the output product.
    logic [COEF_W-1:0]              inv_floor;
    logic [32:0]                    gq_sum;
    logic signed [SAMPLE_BITS+16:0] oprod;

    always_comb begin
        inv_floor = UNITY - r_cfg.floor_gain;
        gq_sum    = 33'(r_gmul) + 33'(r_gmul[31:16]) + 33'd1;
        oprod     = r_delayed * $signed({1'b0, r_gain});
    end

    // State memory: read on acceptance, written back once per item outside bypass.
    always_ff @(posedge i_clk) begin
        if (smp_acc) begin
            r_st_q  <= st_mem[in_ch];
            r_st_vq <= r_st_vld[in_ch];
        end
        if (r_state == S_GUP) begin
            st_mem[r_ch] <= n_st;
        end
    end

    // Delay memory: the new sample goes in while the lookahead tap comes out.
    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD && !r_cfg.bypass) begin
            dly_mem[r_ch][cur.wpos] <= r_x;
            r_dly_q                 <= dly_mem[r_ch][rd_pos];
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (smp_acc) begin
                    r_ch       <= in_ch;
                    r_ch_field <= i_smp.channel_index;
                    r_x        <= i_smp.input_sample;
                end
            end
            S_LOAD: begin
                r_cur      <= cur;
                r_env_prod <= env_prod;
                r_dly_zero <= (dly_amt == '0);
                r_dly_fill <= (dly_amt <= cur.fill);
                r_res      <= r_x;
                r_gopen    <= cur.gate[COEF_W-1];
            end
            S_ENV: begin
                r_env     <= n_env;
                r_delayed <= r_dly_zero ? r_x : (r_dly_fill ? r_dly_q : '0);
            end
            S_GATE: begin
                r_hold  <= n_hold;
                r_gprod <= gprod;
            end
            S_GUP: begin
                r_gate  <= n_gate;
                r_gopen <= n_gate[COEF_W-1];
            end
            S_GMUL: begin
                r_gmul <= ({16'b0, inv_floor} * {16'b0, r_gate}) + Q_HALF;
            end
            S_GDIV: begin
                r_gain <= {1'b0, r_cfg.floor_gain} + {1'b0, gq_sum[31:16]};
            end
            S_APPLY: begin
                r_res <= oprod[SAMPLE_BITS+15:16];
            end
            default: begin
            end
        endcase
    end

    // Sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_st_vld  <= '0;
        end else begin
            // A finished result is loaded when the output register is free or being
            // emptied; otherwise a taken result clears the register.
            if (r_state == S_OUT && (!r_o_valid || o_res.ready)) begin
                r_o_valid  <= 1'b1;
                r_o_chan   <= r_ch_field;
                r_o_sample <= r_res;
                r_o_open   <= r_gopen;
            end else if (o_res.valid && o_res.ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (smp_acc) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD:  r_state <= r_cfg.bypass ? S_OUT : S_ENV;
                S_ENV:   r_state <= S_GATE;
                S_GATE:  r_state <= S_GUP;
                S_GUP: begin
                    r_st_vld[r_ch] <= 1'b1;
                    r_state        <= S_GMUL;
                end
                S_GMUL:  r_state <= S_GDIV;
                S_GDIV:  r_state <= S_APPLY;
                S_APPLY: r_state <= S_OUT;
                S_OUT: begin
                    if (!r_o_valid || o_res.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // An accepted item always starts with the state load.
    a_accept_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        smp_acc |=> (r_state == S_LOAD))
        else $error("accepted item did not enter the load step");

    // A waiting result is never overwritten.
    a_out_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_o_valid && !o_res.ready) |=> (r_state == S_OUT && r_o_valid))
        else $error("result register overwritten while a result waits");

    // Ring position and fill count stay inside the delay depth.
    a_ring_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GUP) |-> (n_st.wpos <= POS_LAST && n_st.fill <= POS_LAST))
        else $error("delay ring pointer out of range");

    // The blended gain never exceeds unity.
    a_gain_unity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY) |-> (r_gain <= 17'd65535))
        else $error("gain above unity");

    // A result appears only out of the output step.
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> ($past(r_state) == S_OUT && r_state == S_IDLE))
        else $error("result raised outside the output step");

endmodule

`default_nettype wire

[tb/sv/audio_noise_gate_tb.sv]
// Self-checking testbench of the audio noise gate: sample driver, result monitor and gate predictor.
`timescale 1ns / 1ps

module audio_noise_gate_tb;

    import ang_pkg::*;

    localparam int RING_DEPTH  = 512;
    localparam int QUIET_LIMIT = 2000;
    localparam int IDLE_PCT    = 29;
    localparam int SQUEEZE_LEN = 300;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_ITEMS = 160;

    typedef struct {
        bit                 ch;
        logic signed [23:0] smp;
    } sample_item_t;

    typedef struct {
        bit                 ch;
        logic signed [23:0] smp;
        bit                 open;
    } gate_result_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ang_in_if  #(.SAMPLE_BITS(DEF_SAMPLE_BITS)) smp_if ();
    ang_out_if #(.SAMPLE_BITS(DEF_SAMPLE_BITS)) res_if ();
    ang_cfg_if                                  cfg_if ();

    audio_noise_gate i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_smp   (smp_if),
        .o_res   (res_if)
    );

    // Clock.
    always #4 i_clk = ~i_clk;

    // Predictor state: settings and per-channel gate state.
    t_cfg               gate_cfg = CFG_RESET;
    longint             env_lvl [2];
    int                 hold_left [2];
    longint             gate_lvl [2];
    logic signed [23:0] ring [2][RING_DEPTH];
    int                 wpos [2];

    sample_item_t sample_backlog[$];
    gate_result_t gated_expect[$];

    bit offer_held;
    bit steady;
    bit squeeze_req;
    bit squeeze_done;
    int squeeze_left;
    int quiet_cycles;

    int samples_taken;
    int results_checked;
    int bypass_items;
    int open_results;
    int reg_writes;
    int settings_used;
    int mismatch_count;

    // One-pole smoothing step with a floored Q0.16 product.
    function automatic longint ease(longint cur, longint tgt, longint coef);
        return cur + ((coef * (tgt - cur)) >>> 16);
    endfunction

    // Advances the state of one channel by one sample and returns its result.
    function automatic gate_result_t gate_predict(bit ch, logic signed [23:0] x);
        gate_result_t res;
        longint xs, mag, env, tgt, gl, gain, dly, p;
        int d, pos;
        xs = x;
        res.ch = ch;
        if (gate_cfg.bypass) begin
            res.smp = x;
            res.open = (gate_lvl[ch] >= 32768);
            return res;
        end
        mag = (xs < 0) ? -xs : xs;
        if (mag > 8388607) mag = 8388607;
        env = env_lvl[ch];
        env = ease(env, mag, (mag > env) ? gate_cfg.attack : gate_cfg.release_c);
        env_lvl[ch] = env;
        // Envelope above threshold reloads the hold; otherwise the hold runs down.
        if (env > longint'(gate_cfg.threshold)) begin
            tgt = 65535;
            hold_left[ch] = gate_cfg.hold_length;
        end else if (hold_left[ch] > 0) begin
            tgt = 65535;
            hold_left[ch]--;
        end else begin
            tgt = 0;
        end
        gl = gate_lvl[ch];
        gl = ease(gl, tgt, (tgt > gl) ? gate_cfg.attack : gate_cfg.release_c);
        gate_lvl[ch] = gl;
        gain = longint'(gate_cfg.floor_gain)
             + ((65535 - longint'(gate_cfg.floor_gain)) * gl + 32767) / 65535;
        // Write the new sample, then read the lookahead tap behind it.
        d = gate_cfg.lookahead;
        pos = wpos[ch];
        ring[ch][pos] = x;
        dly = ring[ch][(pos + RING_DEPTH - d) % RING_DEPTH];
        wpos[ch] = (pos + 1) % RING_DEPTH;
        p = (dly * gain) >>> 16;
        res.smp = p[23:0];
        res.open = (gl >= 32768);
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        mismatch_count++;
        $display("MISMATCH %s at result %0d: got %0d, expected %0d",
                 what, results_checked, got, want);
    endtask

    // Writes one register through the configuration channel.
    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            CFG_THRESHOLD: gate_cfg.threshold   = val[THR_W-1:0];
            CFG_ATTACK:    gate_cfg.attack      = val[COEF_W-1:0];
            CFG_RELEASE:   gate_cfg.release_c   = val[COEF_W-1:0];
            CFG_HOLD:      gate_cfg.hold_length = val[HOLD_W-1:0];
            CFG_FLOOR:     gate_cfg.floor_gain  = val[COEF_W-1:0];
            CFG_LOOKAHEAD: gate_cfg.lookahead   = val[LA_W-1:0];
            CFG_BYPASS:    gate_cfg.bypass      = val[0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // Writes every register of one setting.
    task automatic program_gate(t_cfg c);
        write_reg(CFG_THRESHOLD, 32'(c.threshold));
        write_reg(CFG_ATTACK, 32'(c.attack));
        write_reg(CFG_RELEASE, 32'(c.release_c));
        write_reg(CFG_HOLD, 32'(c.hold_length));
        write_reg(CFG_FLOOR, 32'(c.floor_gain));
        write_reg(CFG_LOOKAHEAD, 32'(c.lookahead));
        write_reg(CFG_BYPASS, 32'(c.bypass));
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
        settings_used++;
    endtask

    function automatic t_cfg pick_setting();
        t_cfg c;
        case ($urandom_range(7))
            0:       c.threshold = '0;
            1:       c.threshold = '1;
            2, 3:    c.threshold = THR_W'($urandom);
            default: c.threshold = THR_W'($urandom_range(1500000, 20000));
        endcase
        case ($urandom_range(5))
            0:       c.attack = '0;
            1:       c.attack = '1;
            default: c.attack = COEF_W'($urandom_range(40000, 500));
        endcase
        case ($urandom_range(5))
            0:       c.release_c = '0;
            1:       c.release_c = '1;
            default: c.release_c = COEF_W'($urandom_range(20000, 50));
        endcase
        case ($urandom_range(5))
            0:       c.hold_length = '0;
            1:       c.hold_length = '1;
            default: c.hold_length = HOLD_W'($urandom_range(60));
        endcase
        case ($urandom_range(3))
            0:       c.floor_gain = '0;
            1:       c.floor_gain = '1;
            default: c.floor_gain = COEF_W'($urandom);
        endcase
        case ($urandom_range(4))
            0:       c.lookahead = '0;
            1:       c.lookahead = '1;
            2:       c.lookahead = LA_W'($urandom);
            default: c.lookahead = LA_W'($urandom_range(20));
        endcase
        c.bypass = ($urandom_range(7) == 0);
        return c;
    endfunction

    task automatic queue_sample(bit ch, logic signed [23:0] x);
        sample_item_t it;
        it.ch = ch;
        it.smp = x;
        sample_backlog.insert(sample_backlog.size(), it);
    endtask

    // Stereo program material: loud bursts, quiet passages, levels near the threshold
    // and some raw noise, so that gates open, hold and close again.
    task automatic queue_program(int count);
        int n, kind, len, i;
        longint m;
        bit ch;
        n = 0;
        while (n < count) begin
            kind = $urandom_range(9);
            len = $urandom_range(24, 1);
            for (i = 0; i < len && n < count; i++) begin
                ch = (kind < 7) ? n[0] : 1'($urandom);
                if (kind < 3)
                    m = $urandom_range(8388607, 1000000);
                else if (kind < 6)
                    m = $urandom_range(255);
                else if (kind < 8) begin
                    m = longint'(gate_cfg.threshold) + $urandom_range(128) - 64;
                    if (m < 0) m = 0;
                    if (m > 8388607) m = 8388607;
                end
                if (kind >= 8)
                    queue_sample(ch, 24'($urandom));
                else
                    queue_sample(ch, $urandom_range(1) ? 24'(-m) : 24'(m));
                n++;
            end
        end
    endtask

    task automatic drain();
        while (sample_backlog.size() != 0 || gated_expect.size() != 0)
            @(posedge i_clk);
    endtask

    // Sample acceptance and prediction.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            offer_held = smp_if.valid && !smp_if.ready;
            if (smp_if.valid && smp_if.ready) begin
                void'(sample_backlog.pop_front());
                if (gate_cfg.bypass) bypass_items++;
                gated_expect.insert(gated_expect.size(),
                                    gate_predict(smp_if.channel_index, smp_if.input_sample));
                samples_taken++;
            end
        end
    end

    // Sample driver: an offered item is held until taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            smp_if.valid <= 1'b0;
        end else if (!offer_held) begin
            if (sample_backlog.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                smp_if.valid         <= 1'b1;
                smp_if.channel_index <= sample_backlog[0].ch;
                smp_if.input_sample  <= sample_backlog[0].smp;
            end else begin
                smp_if.valid <= 1'b0;
            end
        end
    end

    // Result ready: random stalls, plus one long hold-off when requested.
    always @(negedge i_clk) begin
        if (squeeze_req && !squeeze_done) begin
            squeeze_left = SQUEEZE_LEN;
            squeeze_done = 1'b1;
        end
        if (squeeze_left > 0) begin
            squeeze_left--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        gate_result_t want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            results_checked++;
            if (res_if.gate_open) open_results++;
            if (gated_expect.size() == 0) begin
                report_mismatch("unexpected result, sample", res_if.gated_sample, 0);
            end else begin
                want = gated_expect.pop_front();
                if (res_if.out_channel !== want.ch)
                    report_mismatch("out_channel", res_if.out_channel, want.ch);
                if (res_if.gated_sample !== want.smp)
                    report_mismatch("gated_sample", res_if.gated_sample, want.smp);
                if (res_if.gate_open !== want.open)
                    report_mismatch("gate_open", res_if.gate_open, want.open);
            end
        end
    end

    // Watchdog on cycles without any handshake on the sample, result or configuration channel.
    always @(posedge i_clk) begin
        if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready)
                || (cfg_if.valid && cfg_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        t_cfg c;
        int ph;
        i_rst_n              = 1'b0;
        smp_if.valid         = 1'b0;
        smp_if.channel_index = 1'b0;
        smp_if.input_sample  = '0;
        res_if.ready         = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.index         = CFG_THRESHOLD;
        cfg_if.data          = '0;
        foreach (ring[ch, i]) ring[ch][i] = '0;
        foreach (env_lvl[ch]) begin
            env_lvl[ch] = 0;
            hold_left[ch] = 0;
            gate_lvl[ch] = 0;
            wpos[ch] = 0;
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: full-scale samples, the most negative sample, zero and tiny values.
        queue_sample(1'b0, 24'sh7FFFFF);
        queue_sample(1'b1, 24'sh800000);
        queue_sample(1'b0, 24'sh000000);
        queue_sample(1'b1, -24'sd1);
        queue_sample(1'b0, -24'sd8388607);
        queue_sample(1'b1, 24'sd1);
        queue_sample(1'b0, 24'sh7FFFFF);
        queue_sample(1'b0, 24'sh7FFFFF);
        queue_sample(1'b1, 24'sh400000);
        queue_sample(1'b0, 24'sh000000);
        drain();

        // Zero lookahead with the fastest smoothing, no hold and a silent floor.
        c = '{threshold: '0, attack: '1, release_c: '1, hold_length: '0,
              floor_gain: '0, lookahead: '0, bypass: 1'b0};
        program_gate(c);
        queue_sample(1'b0, 24'sh7FFFFF);
        queue_sample(1'b0, 24'sh800000);
        queue_sample(1'b1, -24'sd1);
        queue_sample(1'b1, 24'sh000000);
        queue_sample(1'b0, 24'sd1);
        queue_sample(1'b1, 24'sh800000);
        drain();

        // Longest lookahead, frozen smoothing, longest hold and unity floor.
        c = '{threshold: '1, attack: '0, release_c: '0, hold_length: '1,
              floor_gain: '1, lookahead: '1, bypass: 1'b0};
        program_gate(c);
        queue_sample(1'b1, 24'sh7FFFFF);
        queue_sample(1'b0, 24'sh800000);
        queue_sample(1'b1, 24'sh123456);
        queue_sample(1'b0, -24'sd2);
        drain();

        // Bypass passes samples through with the gate state frozen.
        write_reg(CFG_BYPASS, 32'd1);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
        queue_sample(1'b0, 24'sh7FFFFF);
        queue_sample(1'b1, 24'sh800000);
        queue_sample(1'b0, -24'sd5);
        queue_sample(1'b1, 24'sh000000);
        drain();

        // Random settings with program material; one phase without stalls,
        // one with a long hold-off on the result side.
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            c = pick_setting();
            if (ph == 5) c.bypass = 1'b0;
            program_gate(c);
            steady = (ph == 3);
            queue_program(PHASE_ITEMS);
            if (ph == 5) squeeze_req = 1'b1;
            drain();
            steady = 1'b0;
        end

        repeat (30) @(posedge i_clk);
        $display("covered %0d samples (%0d in bypass) over %0d register settings, %0d writes",
                 samples_taken, bypass_items, settings_used + 1, reg_writes);
        $display("checked %0d results, gate open in %0d, %0d mismatches",
                 results_checked, open_results, mismatch_count);
        if (mismatch_count == 0 && gated_expect.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
